// ===== rtl/set_assoc_cache_lru_lfu_macros.svh =====
// Assertion macros shared by the cache checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef SET_ASSOC_CACHE_LRU_LFU_MACROS_SVH
`define SET_ASSOC_CACHE_LRU_LFU_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SACL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cache checker: same-cycle property failed");

// Next-cycle implication, disabled during reset.
`define SACL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cache checker: next-cycle property failed");

`endif

// ===== rtl/sacl_pkg.sv =====
// Shared types, codes and helpers for the set-associative cache tag store.
// No dependencies; used by the controller, the datapath and the checker.
`default_nettype none

package sacl_pkg;

  // Result status codes.
  localparam logic [1:0] ST_HIT   = 2'd0;
  localparam logic [1:0] ST_FILL  = 2'd1;
  localparam logic [1:0] ST_EVICT = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [1:0] CFG_BLOCK_BITS = 2'd1;
  localparam logic [1:0] CFG_POLICY     = 2'd2;

  // One way of a set as held in the row memory.
  typedef struct packed {
    logic        valid;
    logic [31:0] tag;
    logic [31:0] stamp;
    logic [31:0] uses;
    logic [31:0] base;
  } way_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_SCAN,
    S_WRITE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_we;
    logic accept;
    logic scan_init;
    logic scan_step;
    logic commit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic no_scan;
    logic scan_last;
  } sts_t;

  // Saturating increment that stops at all-ones.
  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (&v) ? v : v + 32'd1;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sacl_ctrl.sv =====
// Controller state machine for the cache tag store.
// Depends on sacl_pkg for the state, command and status types.
`default_nettype none

module sacl_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  input  wire sacl_pkg::sts_t  sts,
  output sacl_pkg::cmd_t       cmd
);

  sacl_pkg::state_t state, state_next;
  logic             out_valid_next;
  logic             slot_free;

  // The result register can take a new beat when empty or being drained.
  assign slot_free = !out_valid || out_ready;

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      sacl_pkg::S_CLEAR: if (sts.clear_last) state_next = sacl_pkg::S_IDLE;
      sacl_pkg::S_IDLE:  if (in_valid) state_next = sacl_pkg::S_LOOK;
      sacl_pkg::S_LOOK: begin
        state_next = sts.no_scan ? sacl_pkg::S_WRITE : sacl_pkg::S_SCAN;
      end
      sacl_pkg::S_SCAN:  if (sts.scan_last) state_next = sacl_pkg::S_WRITE;
      sacl_pkg::S_WRITE: if (slot_free) state_next = sacl_pkg::S_IDLE;
      default:           state_next = sacl_pkg::S_CLEAR;
    endcase
  end

  // Output and command decode.
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      sacl_pkg::S_CLEAR: cmd.clear_we = 1'b1;
      sacl_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.accept = in_valid;
      end
      sacl_pkg::S_LOOK:  cmd.scan_init = 1'b1;
      sacl_pkg::S_SCAN:  cmd.scan_step = 1'b1;
      sacl_pkg::S_WRITE: cmd.commit = slot_free;
      default:           cmd = '0;
    endcase
  end

  // Result valid flag.
  always_comb begin
    out_valid_next = out_valid;
    if (out_ready) out_valid_next = 1'b0;
    if (cmd.commit) out_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sacl_pkg::S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sacl_dp.sv =====
// Datapath of the cache tag store: configuration, row memory, lookup,
// victim scan, counters and the result register. Depends on sacl_pkg.
`default_nettype none

module sacl_dp #(
  parameter int MAX_SET_BITS = 6,
  parameter int WAYS         = 8
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_we,
  input  wire logic [1:0]      cfg_index,
  input  wire logic [3:0]      cfg_data,
  input  wire logic [31:0]     address,
  input  wire sacl_pkg::cmd_t  cmd,
  output sacl_pkg::sts_t       sts,
  output logic [1:0]           status,
  output logic [31:0]          insert_block,
  output logic [31:0]          victim_block,
  output logic [31:0]          hit_total,
  output logic [31:0]          miss_total,
  output logic [31:0]          evict_total
);

  localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int NUM_SETS = 1 << SET_W;
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;

  // Configuration registers.
  logic [2:0] set_bits;
  logic [3:0] block_bits;
  logic       policy_lfu;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits   <= 3'd6;
      block_bits <= 4'd6;
      policy_lfu <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        sacl_pkg::CFG_SET_BITS:   set_bits   <= cfg_data[2:0];
        sacl_pkg::CFG_BLOCK_BITS: block_bits <= cfg_data;
        sacl_pkg::CFG_POLICY:     policy_lfu <= cfg_data[0];
        default:                  ;
      endcase
    end
  end

  // Address split from the current geometry.
  logic [3:0]       sb;
  logic [10:0]      set_mask;
  logic [31:0]      shifted;
  logic [SET_W-1:0] in_set;
  logic [31:0]      in_tag;
  logic [31:0]      in_base;

  always_comb begin
    sb = ({1'b0, set_bits} > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS) : {1'b0, set_bits};
    set_mask = (11'd1 << sb) - 11'd1;
    shifted  = address >> block_bits;
    in_set   = shifted[SET_W-1:0] & set_mask[SET_W-1:0];
    in_tag   = address >> ({1'b0, block_bits} + {1'b0, sb});
    in_base  = shifted << block_bits;
  end

  // Latched access.
  logic [SET_W-1:0] set_q;
  logic [31:0]      tag_q;
  logic [31:0]      base_q;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      set_q  <= in_set;
      tag_q  <= in_tag;
      base_q <= in_base;
    end
  end

  // Row memory: all ways of a set and the set clock, one row per set.
  sacl_pkg::way_t [WAYS-1:0] row_mem [NUM_SETS];
  logic [31:0]               clock_mem [NUM_SETS];
  sacl_pkg::way_t [WAYS-1:0] rdata;
  logic [31:0]               rclock;
  sacl_pkg::way_t [WAYS-1:0] new_row;
  logic [31:0]               now;
  logic [SET_W-1:0]          clear_idx;

  always_ff @(posedge clk) begin
    if (cmd.clear_we) begin
      row_mem[clear_idx]   <= '0;
      clock_mem[clear_idx] <= '0;
    end else if (cmd.commit) begin
      row_mem[set_q]   <= new_row;
      clock_mem[set_q] <= now;
    end
    if (cmd.accept) begin
      rdata  <= row_mem[in_set];
      rclock <= clock_mem[in_set];
    end
  end

  // Clearing pass counter after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_idx <= '0;
    end else if (cmd.clear_we) begin
      clear_idx <= clear_idx + SET_W'(1);
    end
  end

  // Hit and free-way search, lowest way first.
  logic             hit;
  logic [WAY_W-1:0] hit_w;
  logic             free;
  logic [WAY_W-1:0] free_w;

  always_comb begin
    hit    = 1'b0;
    hit_w  = '0;
    free   = 1'b0;
    free_w = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (rdata[i].valid && rdata[i].tag == tag_q) begin
        hit   = 1'b1;
        hit_w = WAY_W'(i);
      end
      if (!rdata[i].valid) begin
        free   = 1'b1;
        free_w = WAY_W'(i);
      end
    end
    now = sacl_pkg::sat_inc(rclock);
  end

  // Victim scan, one way per cycle.
  logic [WAY_W-1:0] scan_way;
  logic [WAY_W-1:0] victim;
  sacl_pkg::way_t   cand;
  sacl_pkg::way_t   cur;
  logic             take;

  always_comb begin
    cand = rdata[scan_way];
    cur  = rdata[victim];
    if (policy_lfu) begin
      take = (cand.uses < cur.uses) ||
             (cand.uses == cur.uses && cand.stamp < cur.stamp);
    end else begin
      take = cand.stamp < cur.stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      victim   <= '0;
      scan_way <= WAY_W'(1);
    end else if (cmd.scan_step) begin
      if (take) victim <= scan_way;
      scan_way <= scan_way + WAY_W'(1);
    end
  end

  assign sts.clear_last = &clear_idx;
  assign sts.no_scan    = hit || free || (WAYS == 1);
  assign sts.scan_last  = (scan_way == WAY_W'(WAYS - 1));

  // Updated row for write-back.
  always_comb begin
    new_row = rdata;
    if (hit) begin
      new_row[hit_w].stamp = now;
      new_row[hit_w].uses  = sacl_pkg::sat_inc(rdata[hit_w].uses);
    end else if (free) begin
      new_row[free_w] = '{valid: 1'b1, tag: tag_q, stamp: now, uses: 32'd1, base: base_q};
    end else begin
      new_row[victim] = '{valid: 1'b1, tag: tag_q, stamp: now, uses: 32'd1, base: base_q};
    end
  end

  // Running totals.
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_total   <= '0;
      miss_total  <= '0;
      evict_total <= '0;
    end else if (cmd.commit) begin
      if (hit) begin
        hit_total <= sacl_pkg::sat_inc(hit_total);
      end else begin
        miss_total <= sacl_pkg::sat_inc(miss_total);
        if (!free) evict_total <= sacl_pkg::sat_inc(evict_total);
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (hit) begin
        status       <= sacl_pkg::ST_HIT;
        insert_block <= '0;
        victim_block <= '0;
      end else if (free) begin
        status       <= sacl_pkg::ST_FILL;
        insert_block <= base_q;
        victim_block <= '0;
      end else begin
        status       <= sacl_pkg::ST_EVICT;
        insert_block <= base_q;
        victim_block <= rdata[victim].base;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/set_assoc_cache_lru_lfu.sv =====
// Top level of the set-associative cache tag store with LRU/LFU replacement.
// Depends on sacl_pkg, sacl_ctrl and sacl_dp.
//
//   channel  signals                     direction  beat
//   in       in_valid/in_ready, address  input      one byte address
//   out      out_valid/out_ready, status output     one lookup result
//   cfg      cfg_we, cfg_index, cfg_data input      one register write
//
// An address that hits or fills an empty way passes through accept, lookup
// and write-back; an eviction also runs the victim scan, which compares one
// way per cycle, between lookup and write-back.
// One row read and one row write-back of the set memory per access.
// After reset a clearing pass over all 2**MAX_SET_BITS rows (2 when zero)
// runs before the first address is accepted.
// A waiting result stalls the next write-back; one further address can be
// accepted and looked up meanwhile.
`default_nettype none

module set_assoc_cache_lru_lfu #(
  parameter int MAX_SET_BITS = 6,
  parameter int WAYS         = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] address,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic [31:0]      insert_block,
  output logic [31:0]      victim_block,
  output logic [31:0]      hit_total,
  output logic [31:0]      miss_total,
  output logic [31:0]      evict_total,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [3:0]  cfg_data
);

  sacl_pkg::cmd_t cmd;
  sacl_pkg::sts_t sts;

  // Sequencing.
  sacl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Storage and arithmetic.
  sacl_dp #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .WAYS         (WAYS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .address      (address),
    .cmd          (cmd),
    .sts          (sts),
    .status       (status),
    .insert_block (insert_block),
    .victim_block (victim_block),
    .hit_total    (hit_total),
    .miss_total   (miss_total),
    .evict_total  (evict_total)
  );

endmodule

`default_nettype wire

// ===== rtl/sacl_checker.sv =====
// Port-level checker for the cache tag store, bound to the top level.
// Depends on sacl_pkg and set_assoc_cache_lru_lfu_macros.svh.
`default_nettype none
`include "set_assoc_cache_lru_lfu_macros.svh"

module sacl_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  status,
  input wire logic [31:0] insert_block,
  input wire logic [31:0] victim_block
);

  logic status_known;
  logic is_hit;
  logic is_fill;
  logic no_blocks;

  // Decoded views of the result beat.
  assign is_hit       = (status == sacl_pkg::ST_HIT);
  assign is_fill      = (status == sacl_pkg::ST_FILL);
  assign status_known = is_hit || is_fill || (status == sacl_pkg::ST_EVICT);
  assign no_blocks    = (insert_block == 32'd0) && (victim_block == 32'd0);

  // A stalled result beat holds its status.
  `SACL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status))

  // Status never takes an unused code.
  `SACL_ASSERT_NOW(a_status_code, out_valid, status_known)

  // A hit reports no block addresses.
  `SACL_ASSERT_NOW(a_hit_zero, out_valid && is_hit, no_blocks)

  // A fill into an empty way reports no victim.
  `SACL_ASSERT_NOW(a_fill_zero, out_valid && is_fill, victim_block == 32'd0)

  // Only one address is in work at a time.
  `SACL_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)

endmodule

bind set_assoc_cache_lru_lfu sacl_checker u_sacl_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .status       (status),
  .insert_block (insert_block),
  .victim_block (victim_block)
);

`default_nettype wire

// ===== tb/sv/set_assoc_cache_lru_lfu_tb.sv =====
// Self-checking bench for the set-associative cache tag store with LRU/LFU replacement.
// Depends on sacl_pkg and set_assoc_cache_lru_lfu; keeps its own model of the tag store.
`default_nettype none

module set_assoc_cache_lru_lfu_tb;

  localparam int MSB = 6;
  localparam int NW = 8;
  localparam int NSETS = 1 << MSB;
  localparam longint CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [31:0] address = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] status;
  logic [31:0] insert_block, victim_block, hit_total, miss_total, evict_total;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [3:0] cfg_data = '0;

  typedef struct packed {
    logic [1:0] status;
    logic [31:0] ins;
    logic [31:0] vic;
    logic [31:0] hits;
    logic [31:0] misses;
    logic [31:0] evicts;
  } lookup_t;

  // Model of the tag store.
  logic [2:0] m_set_bits;
  logic [3:0] m_block_bits;
  logic m_lfu;
  logic m_valid [NSETS*NW];
  logic [31:0] m_tag [NSETS*NW];
  logic [31:0] m_stamp [NSETS*NW];
  logic [31:0] m_uses [NSETS*NW];
  logic [31:0] m_base [NSETS*NW];
  logic [31:0] m_clock [NSETS];
  logic [31:0] m_hits, m_misses, m_evicts;

  lookup_t lookups_due[$];
  int mismatches = 0;
  int results_seen = 0;
  longint cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 1'b0;

  set_assoc_cache_lru_lfu #(.MAX_SET_BITS(MSB), .WAYS(NW)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .address(address),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .insert_block(insert_block), .victim_block(victim_block),
    .hit_total(hit_total), .miss_total(miss_total), .evict_total(evict_total),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [31:0] bump(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  // Work out the result of one lookup and update the model.
  function automatic lookup_t predict_lookup(input logic [31:0] a);
    lookup_t r;
    int sb, bb, s, first, w, hit_w, free_w, v;
    logic [31:0] tg, bs, now;
    logic take;
    sb = (m_set_bits > MSB) ? MSB : m_set_bits;
    bb = m_block_bits;
    s = (sb == 0) ? 0 : ((a >> bb) & ((1 << sb) - 1));
    tg = 32'(64'(a) >> (bb + sb));
    bs = (a >> bb) << bb;
    first = s * NW;
    m_clock[s] = bump(m_clock[s]);
    now = m_clock[s];
    r = '0;
    hit_w = -1;
    free_w = -1;
    for (w = NW - 1; w >= 0; w--) begin
      if (m_valid[first+w] && m_tag[first+w] == tg) hit_w = w;
      if (!m_valid[first+w]) free_w = w;
    end
    if (hit_w >= 0) begin
      m_stamp[first+hit_w] = now;
      m_uses[first+hit_w] = bump(m_uses[first+hit_w]);
      m_hits = bump(m_hits);
      r.status = sacl_pkg::ST_HIT;
    end else begin
      r.ins = bs;
      m_misses = bump(m_misses);
      if (free_w >= 0) begin
        v = first + free_w;
        r.status = sacl_pkg::ST_FILL;
      end else begin
        v = first;
        for (w = 1; w < NW; w++) begin
          if (m_lfu)
            take = m_uses[first+w] < m_uses[v] ||
                   (m_uses[first+w] == m_uses[v] && m_stamp[first+w] < m_stamp[v]);
          else
            take = m_stamp[first+w] < m_stamp[v];
          if (take) v = first + w;
        end
        r.vic = m_base[v];
        m_evicts = bump(m_evicts);
        r.status = sacl_pkg::ST_EVICT;
      end
      m_valid[v] = 1'b1;
      m_tag[v] = tg;
      m_base[v] = bs;
      m_stamp[v] = now;
      m_uses[v] = 32'd1;
    end
    r.hits = m_hits;
    r.misses = m_misses;
    r.evicts = m_evicts;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch on %s: got %h, expected %h (result %0d)", what, got, want,
             results_seen);
    mismatches++;
  endtask

  // Cycle counter and timeout.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Receiver: stalls at random, or for long stretches while hold_off is set.
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  // Checker: compare each result beat with the oldest prediction.
  always @(posedge clk) begin
    lookup_t e;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (lookups_due.size() == 0) begin
        report_mismatch("unexpected result beat", 32'(status), 32'd0);
      end else begin
        e = lookups_due.pop_front();
        if (status !== e.status) report_mismatch("status", 32'(status), 32'(e.status));
        if (insert_block !== e.ins) report_mismatch("insert_block", insert_block, e.ins);
        if (victim_block !== e.vic) report_mismatch("victim_block", victim_block, e.vic);
        if (hit_total !== e.hits) report_mismatch("hit_total", hit_total, e.hits);
        if (miss_total !== e.misses) report_mismatch("miss_total", miss_total, e.misses);
        if (evict_total !== e.evicts) report_mismatch("evict_total", evict_total, e.evicts);
      end
    end
  end

  // Offer one address beat and wait until it is accepted.
  // Valid drops only while the sender idles or when the bench drains.
  task automatic send_address(input logic [31:0] a);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    address <= a;
    lookups_due.push_back(predict_lookup(a));
    do @(posedge clk); while (!in_ready);
  endtask

  // Wait until every expected result has come, then let the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (lookups_due.size() != 0) @(posedge clk);
    repeat (NW + 8) @(posedge clk);
  endtask

  // One register write; the caller drops the write enable afterwards.
  task automatic write_register(input logic [1:0] idx, input logic [3:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      sacl_pkg::CFG_SET_BITS: m_set_bits = val[2:0];
      sacl_pkg::CFG_BLOCK_BITS: m_block_bits = val;
      sacl_pkg::CFG_POLICY: m_lfu = val[0];
      default: ;
    endcase
  endtask

  task automatic configure(input int sb, input int bb, input int lfu);
    drain();
    write_register(sacl_pkg::CFG_SET_BITS, 4'(sb));
    write_register(sacl_pkg::CFG_BLOCK_BITS, 4'(bb));
    write_register(sacl_pkg::CFG_POLICY, 4'(lfu));
    cfg_we <= 1'b0;
  endtask

  // Address in a small working set so that sets fill and evict.
  function automatic logic [31:0] working_set_address();
    logic [31:0] a;
    a = $urandom;
    if ($urandom_range(9) < 8) begin
      a[31:12] = 20'($urandom_range(15));
      a[31:28] = 4'($urandom_range(1));
    end
    return a;
  endfunction

  // Directed: field extremes, hits, fills, evictions and duplicate tags.
  task automatic test_directed();
    int i;
    send_address(32'h0000_0000);
    send_address(32'hFFFF_FFFF);
    send_address(32'h0000_0000);
    send_address(32'h8000_0000);
    send_address(32'h5555_5555);
    send_address(32'hAAAA_AAAA);
    // Ten distinct tags into set zero fill it and then evict under LRU.
    for (i = 0; i < 10; i++) send_address(32'(i) << 12);
    send_address(32'h0000_1000);
    // Shrink to one set with 16-byte blocks: earlier lines may now match twice.
    configure(0, 4, 1);
    for (i = 0; i < 9; i++) send_address(32'(i % 3) << 12);
  endtask

  // Random phase under one geometry and one idling pattern.
  task automatic test_random(input int n, input int sb, input int bb, input int lfu,
                             input int idle, input int stall);
    int i;
    configure(sb, bb, lfu);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (i = 0; i < n; i++) send_address(working_set_address());
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering.
  task automatic test_backpressure();
    int i;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
      for (i = 0; i < 20; i++) send_address(working_set_address());
    join
    drain();
  endtask

  initial begin
    int i;
    m_set_bits = 3'd6;
    m_block_bits = 4'd6;
    m_lfu = 1'b0;
    for (i = 0; i < NSETS * NW; i++) begin
      m_valid[i] = 1'b0;
      m_tag[i] = '0;
      m_stamp[i] = '0;
      m_uses[i] = '0;
      m_base[i] = '0;
    end
    for (i = 0; i < NSETS; i++) m_clock[i] = '0;
    m_hits = '0;
    m_misses = '0;
    m_evicts = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(100, 6, 6, 0, 0, 0);
    test_random(100, 2, 12, 1, 67, 0);
    test_random(100, 7, 0, 0, 0, 67);
    test_random(100, 0, 15, 1, 8, 8);
    test_random(100, 3, 4, 1, 0, 0);
    test_backpressure();
    test_random(80, 1, 9, 0, 67, 67);
    drain();
    $display("covered %0d lookups over several geometries, both policies,", results_seen);
    $display("random idling on both sides and a long receiver hold-off");
    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/sacl_pkg.sv
rtl/sacl_ctrl.sv
rtl/sacl_dp.sv
rtl/set_assoc_cache_lru_lfu.sv
rtl/sacl_checker.sv
tb/sv/set_assoc_cache_lru_lfu_tb.sv
